/* design/txcw_pkg.sv */
// Shared types and constants for the text console cell writer.
// Request and result words, request codes, character codes, default geometry.
// No dependencies.
`default_nettype none

package txcw_pkg;

  localparam int DEFAULT_COLUMNS = 80;
  localparam int DEFAULT_ROWS    = 25;
  localparam int POS_W           = 11;

  localparam logic [2:0] REQ_PUT_CURSOR = 3'd0;
  localparam logic [2:0] REQ_PUT_AT     = 3'd1;
  localparam logic [2:0] REQ_SET_ROW    = 3'd2;
  localparam logic [2:0] REQ_SET_COL    = 3'd3;
  localparam logic [2:0] REQ_READ       = 3'd4;

  localparam logic [7:0]  CHR_NEWLINE   = 8'd10;
  localparam logic [7:0]  CHR_BACKSPACE = 8'd8;
  localparam logic [7:0]  CHR_SPACE     = 8'd32;
  localparam logic [15:0] BLANK_CELL    = 16'h0720;
  localparam logic [7:0]  ATTR_RESET    = 8'd7;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] char_code;
    logic [7:0] cell_attribute;
    logic [7:0] row_value;
    logic [7:0] col_value;
  } req_t;

  typedef struct packed {
    logic [POS_W-1:0] cursor_position;
    logic [15:0]      cell_data;
    logic             status;
    logic             screen_cleared;
  } rsp_t;

endpackage

`default_nettype wire

/* design/text_console_cell_writer.sv */
// Text console cell writer: screen store, cursor, request sequencer.
// Depends on txcw_pkg.
//
// A request word is taken when start is high and busy is low; its result word
// appears on rsp with done high for exactly one cycle and cannot be held off.
// Every address (row * COLUMNS + col) is formed by one shared adder doing a
// shift-add over the row bits, one bit a cycle. A request without a store
// access steps through S_POS alone, one with a store access through S_ADDR,
// S_MEM and S_POS; done rises in the same cycle that busy falls, and a new
// request can be taken in that cycle. The same adder walks the store one cell a
// cycle when the screen is cleared: after reset busy stays high until every
// cell is blank, and a character that runs past the last row adds a full clear.
`default_nettype none

module text_console_cell_writer
  import txcw_pkg::*;
#(
  parameter int COLUMNS = DEFAULT_COLUMNS,
  parameter int ROWS    = DEFAULT_ROWS
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire req_t       req,
  output logic            done,
  output rsp_t            rsp,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_data
);

  localparam int ROW_W = $clog2(ROWS);
  localparam int COL_W = $clog2(COLUMNS);
  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = (ROW_W > 1) ? $clog2(ROW_W) : 1;
  localparam int XW    = (AW > POS_W) ? AW : POS_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ADDR  = 3'd1;
  localparam logic [2:0] S_MEM   = 3'd2;
  localparam logic [2:0] S_CLEAR = 3'd3;
  localparam logic [2:0] S_POS   = 3'd4;

  logic [2:0]       state;
  logic [ROW_W-1:0] cur_row;
  logic [COL_W-1:0] cur_col;
  logic [7:0]       text_attribute;
  logic [AW-1:0]    clear_idx;
  logic             boot;
  logic [AW-1:0]    acc;
  logic [AW-1:0]    addend;
  logic [ROW_W-1:0] mul_row;
  logic [CW-1:0]    bit_cnt;
  logic             do_wr;
  logic             do_rd;
  logic             clr_pend;
  logic             status_r;
  logic [15:0]      wr_word;
  logic [15:0]      rd_data;
  logic [15:0]      cells [CELLS];

  logic [AW-1:0]    alu_a;
  logic [AW-1:0]    alu_b;
  logic [AW-1:0]    alu_sum;
  logic [XW-1:0]    pos_ext;
  logic             bit_last;
  logic             clear_last;
  logic             accept;

  logic [ROW_W-1:0] t_row;
  logic [COL_W-1:0] t_col;
  logic [ROW_W:0]   n_row;
  logic [COL_W-1:0] n_col;
  logic             a_wr;
  logic             a_rd;
  logic             a_status;
  logic [15:0]      a_word;
  logic             on_screen;
  logic             need_clear;

  logic             mem_we;
  logic [AW-1:0]    mem_addr;
  logic [15:0]      mem_wdata;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // shared adder
  always_comb begin
    if (state == S_CLEAR) begin
      alu_a = clear_idx;
      alu_b = AW'(1);
    end else begin
      alu_a = acc;
      alu_b = addend;
    end
  end
  assign alu_sum    = alu_a + alu_b;
  assign pos_ext    = XW'(mul_row[0] ? alu_sum : acc);
  assign bit_last   = (bit_cnt == CW'(ROW_W - 1));
  assign clear_last = (clear_idx == AW'(CELLS - 1));

  assign on_screen = ({1'b0, req.row_value} < 9'(ROWS)) && ({1'b0, req.col_value} < 9'(COLUMNS));

  always_comb begin
    t_row    = cur_row;
    t_col    = cur_col;
    n_row    = {1'b0, cur_row};
    n_col    = cur_col;
    a_wr     = 1'b0;
    a_rd     = 1'b0;
    a_status = 1'b0;
    a_word   = {text_attribute, req.char_code};
    unique case (req.req_type)
      REQ_PUT_CURSOR: begin
        if (req.char_code == CHR_NEWLINE) begin
          n_row = {1'b0, cur_row} + (ROW_W+1)'(1);
          n_col = '0;
        end else if (req.char_code == CHR_BACKSPACE) begin
          if (cur_col != '0) begin
            t_col  = cur_col - COL_W'(1);
            n_col  = cur_col - COL_W'(1);
            a_wr   = 1'b1;
            a_word = {text_attribute, CHR_SPACE};
          end
        end else begin
          a_wr = 1'b1;
          if (cur_col == COL_W'(COLUMNS - 1)) begin
            n_col = '0;
            n_row = {1'b0, cur_row} + (ROW_W+1)'(1);
          end else begin
            n_col = cur_col + COL_W'(1);
          end
        end
      end
      REQ_PUT_AT: begin
        t_row  = req.row_value[ROW_W-1:0];
        t_col  = req.col_value[COL_W-1:0];
        a_word = {req.cell_attribute, req.char_code};
        a_wr   = on_screen;
        a_status = !on_screen;
      end
      REQ_SET_ROW: begin
        n_row = (req.row_value >= 8'(ROWS)) ? (ROW_W+1)'(ROWS - 1)
                                             : {1'b0, req.row_value[ROW_W-1:0]};
      end
      REQ_SET_COL: begin
        n_col = (req.col_value >= 8'(COLUMNS)) ? COL_W'(COLUMNS - 1)
                                                : req.col_value[COL_W-1:0];
      end
      REQ_READ: begin
        t_row    = req.row_value[ROW_W-1:0];
        t_col    = req.col_value[COL_W-1:0];
        a_rd     = on_screen;
        a_status = !on_screen;
      end
      default: begin
      end
    endcase
  end

  assign need_clear = (req.req_type == REQ_PUT_CURSOR) && (n_row == (ROW_W+1)'(ROWS));

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLEAR;
      cur_row        <= '0;
      cur_col        <= '0;
      text_attribute <= ATTR_RESET;
      clear_idx      <= '0;
      boot           <= 1'b1;
      done           <= 1'b0;
      clr_pend       <= 1'b0;
      do_wr          <= 1'b0;
      do_rd          <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        text_attribute <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            do_wr    <= a_wr;
            do_rd    <= a_rd;
            status_r <= a_status;
            wr_word  <= a_word;
            clr_pend <= need_clear;
            if (need_clear) begin
              cur_row <= '0;
              cur_col <= '0;
            end else begin
              cur_row <= n_row[ROW_W-1:0];
              cur_col <= n_col;
            end
            bit_cnt <= '0;
            addend  <= AW'(COLUMNS);
            if (a_wr || a_rd) begin
              acc     <= AW'(t_col);
              mul_row <= t_row;
              state   <= S_ADDR;
            end else if (need_clear) begin
              clear_idx <= '0;
              state     <= S_CLEAR;
            end else begin
              acc     <= AW'(n_col);
              mul_row <= n_row[ROW_W-1:0];
              state   <= S_POS;
            end
          end
        end
        S_ADDR: begin
          acc     <= pos_ext[AW-1:0];
          mul_row <= mul_row >> 1;
          addend  <= addend << 1;
          bit_cnt <= bit_cnt + CW'(1);
          if (bit_last) begin
            state <= S_MEM;
          end
        end
        S_MEM: begin
          bit_cnt <= '0;
          addend  <= AW'(COLUMNS);
          acc     <= AW'(cur_col);
          mul_row <= cur_row;
          if (clr_pend) begin
            clear_idx <= '0;
            state     <= S_CLEAR;
          end else begin
            state <= S_POS;
          end
        end
        S_CLEAR: begin
          clear_idx <= alu_sum;
          if (clear_last) begin
            clear_idx <= '0;
            bit_cnt   <= '0;
            addend    <= AW'(COLUMNS);
            acc       <= '0;
            mul_row   <= '0;
            boot      <= 1'b0;
            state     <= boot ? S_IDLE : S_POS;
          end
        end
        S_POS: begin
          acc     <= pos_ext[AW-1:0];
          mul_row <= mul_row >> 1;
          addend  <= addend << 1;
          bit_cnt <= bit_cnt + CW'(1);
          if (bit_last) begin
            rsp.cursor_position <= pos_ext[POS_W-1:0];
            rsp.cell_data       <= do_rd ? rd_data : 16'h0000;
            rsp.status          <= status_r;
            rsp.screen_cleared  <= clr_pend;
            done                <= 1'b1;
            state               <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // screen store
  assign mem_we    = ((state == S_MEM) && do_wr) || (state == S_CLEAR);
  assign mem_addr  = (state == S_CLEAR) ? clear_idx : acc;
  assign mem_wdata = (state == S_CLEAR) ? BLANK_CELL : wr_word;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      cells[mem_addr] <= mem_wdata;
    end
    if ((state == S_MEM) && do_rd) begin
      rd_data <= cells[acc];
    end
  end

  a_done_after_pos: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_POS))
    else $error("result word without address step");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("request taken but sequencer idle");

  a_addr_range: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (mem_addr < AW'(CELLS)))
    else $error("store write outside screen");

  a_clear_home: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.screen_cleared) |-> (rsp.cursor_position == '0))
    else $error("cursor not home after screen clear");

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
// Self-checking bench for text_console_cell_writer: directed console cases,
// attribute sweeps and random request traffic under sender idling.
// Depends on txcw_pkg and the text_console_cell_writer RTL.
`timescale 1ns / 1ps

module tb_top;
  import txcw_pkg::*;

  localparam int NCOL          = DEFAULT_COLUMNS;
  localparam int NROW          = DEFAULT_ROWS;
  localparam int NCELL         = NCOL * NROW;
  localparam int LIMIT_CYCLES  = 20_000_000;
  localparam int SETTLE_CYCLES = 20;
  localparam int PRINT_CAP     = 40;

  localparam logic [2:0] REQ_UNUSED_LO = 3'd5;
  localparam logic [2:0] REQ_UNUSED_HI = 3'd7;

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  req_t       req;
  logic       done;
  rsp_t       rsp;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [7:0] cfg_data;

  text_console_cell_writer u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .done      (done),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // shadow of the console
  logic [15:0] shadow_cells [0:NCELL-1];
  int          shadow_row;
  int          shadow_col;
  logic [7:0]  shadow_attr;

  rsp_t console_results_q [$];

  int idle_pct;
  int words_sent;
  int results_checked;
  int clears_seen;
  int mismatch_count;
  int cycle_count;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_top: errors");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP) $display("MISMATCH %0t ns: %s", $time, msg);
  endtask

  function automatic void blank_screen();
    int i;
    for (i = 0; i < NCELL; i++) shadow_cells[i] = BLANK_CELL;
    shadow_row = 0;
    shadow_col = 0;
  endfunction

  function automatic rsp_t console_step(input req_t r);
    rsp_t o;
    bit   on_screen;
    int   pos;
    o = '0;
    on_screen = (int'(r.row_value) < NROW) && (int'(r.col_value) < NCOL);
    case (r.req_type)
      REQ_PUT_CURSOR: begin
        if (r.char_code == CHR_NEWLINE) begin
          shadow_row++;
          shadow_col = 0;
        end else if (r.char_code == CHR_BACKSPACE) begin
          if (shadow_col > 0) begin
            shadow_col--;
            shadow_cells[shadow_row * NCOL + shadow_col] = {shadow_attr, CHR_SPACE};
          end
        end else begin
          shadow_cells[shadow_row * NCOL + shadow_col] = {shadow_attr, r.char_code};
          shadow_col++;
          if (shadow_col >= NCOL) begin
            shadow_col = 0;
            shadow_row++;
          end
        end
        if (shadow_row >= NROW) begin
          blank_screen();
          o.screen_cleared = 1'b1;
        end
      end
      REQ_PUT_AT: begin
        if (on_screen)
          shadow_cells[int'(r.row_value) * NCOL + int'(r.col_value)] =
            {r.cell_attribute, r.char_code};
        else
          o.status = 1'b1;
      end
      REQ_SET_ROW: shadow_row = (int'(r.row_value) >= NROW) ? NROW - 1 : int'(r.row_value);
      REQ_SET_COL: shadow_col = (int'(r.col_value) >= NCOL) ? NCOL - 1 : int'(r.col_value);
      REQ_READ: begin
        if (on_screen)
          o.cell_data = shadow_cells[int'(r.row_value) * NCOL + int'(r.col_value)];
        else
          o.status = 1'b1;
      end
      default: ;
    endcase
    pos = shadow_row * NCOL + shadow_col;
    o.cursor_position = pos[POS_W-1:0];
    return o;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (!rst && done) begin
      if (console_results_q.size() == 0) begin
        report_mismatch($sformatf("result word with none pending: %h", rsp));
      end else begin
        want = console_results_q.pop_front();
        results_checked++;
        if (rsp.screen_cleared === 1'b1) clears_seen++;
        if (rsp.cursor_position !== want.cursor_position)
          report_mismatch($sformatf("cursor_position got %0d want %0d",
                                    rsp.cursor_position, want.cursor_position));
        if (rsp.cell_data !== want.cell_data)
          report_mismatch($sformatf("cell_data got %h want %h",
                                    rsp.cell_data, want.cell_data));
        if (rsp.status !== want.status)
          report_mismatch($sformatf("status got %b want %b", rsp.status, want.status));
        if (rsp.screen_cleared !== want.screen_cleared)
          report_mismatch($sformatf("screen_cleared got %b want %b",
                                    rsp.screen_cleared, want.screen_cleared));
      end
    end
  end

  function automatic req_t req_word(input logic [2:0] kind, input logic [7:0] ch,
                                    input logic [7:0] attr, input logic [7:0] row,
                                    input logic [7:0] col);
    req_t w;
    w.req_type       = kind;
    w.char_code      = ch;
    w.cell_attribute = attr;
    w.row_value      = row;
    w.col_value      = col;
    return w;
  endfunction

  task automatic send_word(input req_t w);
    start <= 1'b1;
    req   <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    console_results_q.push_back(console_step(w));
    words_sent++;
  endtask

  task automatic pace();
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (console_results_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_text_attribute(input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid   <= 1'b0;
    shadow_attr = value;
  endtask

  function automatic req_t random_word();
    req_t        w;
    int unsigned p;
    int unsigned c;
    w.char_code      = 8'($urandom_range(255));
    w.cell_attribute = 8'($urandom_range(255));
    w.row_value      = 8'($urandom_range(NROW - 1));
    w.col_value      = 8'($urandom_range(NCOL - 1));
    w.req_type       = REQ_PUT_CURSOR;
    p = $urandom_range(99);
    if (p < 45) begin
      c = $urandom_range(99);
      if (c < 8) w.char_code = CHR_NEWLINE;
      else if (c < 15) w.char_code = CHR_BACKSPACE;
    end else if (p < 60) begin
      w.req_type = REQ_PUT_AT;
    end else if (p < 74) begin
      w.req_type = REQ_READ;
      if ($urandom_range(4) < 2) w.row_value = 8'(shadow_row);
    end else if (p < 81) begin
      w.req_type = REQ_SET_ROW;
      if ($urandom_range(2) == 0) w.row_value = 8'(NROW - 1);
      else if ($urandom_range(4) == 0) w.row_value = 8'($urandom_range(255));
    end else if (p < 87) begin
      w.req_type = REQ_SET_COL;
      if ($urandom_range(3) == 0) w.col_value = 8'(NCOL - 1 - int'($urandom_range(3)));
      else if ($urandom_range(4) == 0) w.col_value = 8'($urandom_range(255));
    end else if (p < 96) begin
      w.req_type  = $urandom_range(1) ? REQ_PUT_AT : REQ_READ;
      w.row_value = 8'($urandom_range(255));
      w.col_value = 8'($urandom_range(255));
    end else begin
      w.req_type = 3'($urandom_range(REQ_UNUSED_HI, REQ_UNUSED_LO));
    end
    return w;
  endfunction

  task automatic test_directed_cases();
    send_word(req_word(REQ_READ, 8'h00, 8'h00, 8'd0, 8'd0));
    send_word(req_word(REQ_READ, 8'hFF, 8'hFF, 8'(NROW - 1), 8'(NCOL - 1)));
    send_word(req_word(REQ_PUT_CURSOR, "A", 8'h00, 8'd0, 8'd0));
    send_word(req_word(REQ_PUT_CURSOR, CHR_BACKSPACE, 8'h00, 8'd0, 8'd0));
    // backspace at column zero
    send_word(req_word(REQ_PUT_CURSOR, CHR_BACKSPACE, 8'hFF, 8'hFF, 8'hFF));
    send_word(req_word(REQ_SET_COL, 8'h00, 8'h00, 8'h00, 8'hFF));
    send_word(req_word(REQ_PUT_CURSOR, 8'hFF, 8'hFF, 8'h00, 8'h00));
    send_word(req_word(REQ_PUT_CURSOR, CHR_NEWLINE, 8'h00, 8'h00, 8'h00));
    send_word(req_word(REQ_SET_ROW, 8'h00, 8'h00, 8'hFF, 8'h00));
    send_word(req_word(REQ_PUT_AT, 8'h00, 8'hFF, 8'(NROW - 1), 8'(NCOL - 1)));
    send_word(req_word(REQ_PUT_AT, CHR_NEWLINE, 8'h00, 8'd0, 8'd0));
    send_word(req_word(REQ_PUT_AT, CHR_BACKSPACE, 8'h5A, 8'd1, 8'd5));
    send_word(req_word(REQ_PUT_AT, "x", 8'h11, 8'(NROW), 8'd0));
    send_word(req_word(REQ_PUT_AT, "y", 8'h22, 8'd0, 8'(NCOL)));
    send_word(req_word(REQ_READ, 8'h00, 8'h00, 8'hFF, 8'hFF));
    send_word(req_word(REQ_READ, 8'h00, 8'h00, 8'd0, 8'd0));
    send_word(req_word(REQ_READ, 8'h00, 8'h00, 8'd1, 8'd5));
    send_word(req_word(REQ_READ, 8'h00, 8'h00, 8'(NROW - 1), 8'(NCOL - 1)));
    send_word(req_word(REQ_UNUSED_LO, 8'hFF, 8'hFF, 8'd3, 8'd3));
    send_word(req_word(REQ_UNUSED_HI, 8'h00, 8'h00, 8'hFF, 8'hFF));
    send_word(req_word(REQ_SET_COL, 8'h00, 8'h00, 8'h00, 8'h00));
    // newline on the last row clears the screen
    send_word(req_word(REQ_SET_ROW, 8'h00, 8'h00, 8'(NROW - 1), 8'h00));
    send_word(req_word(REQ_PUT_CURSOR, CHR_NEWLINE, 8'h00, 8'h00, 8'h00));
    send_word(req_word(REQ_READ, 8'h00, 8'h00, 8'(NROW - 1), 8'(NCOL - 1)));
    send_word(req_word(REQ_READ, 8'h00, 8'h00, 8'd0, 8'd0));
  endtask

  task automatic attribute_pass(input logic [7:0] attr);
    drain_results();
    set_text_attribute(attr);
    send_word(req_word(REQ_PUT_CURSOR, "Q", 8'h00, 8'h00, 8'h00));
    send_word(req_word(REQ_PUT_CURSOR, "R", 8'h00, 8'h00, 8'h00));
    send_word(req_word(REQ_READ, 8'h00, 8'h00, 8'(shadow_row), 8'(shadow_col - 1)));
    send_word(req_word(REQ_PUT_CURSOR, CHR_BACKSPACE, 8'h00, 8'h00, 8'h00));
    send_word(req_word(REQ_READ, 8'h00, 8'h00, 8'(shadow_row), 8'(shadow_col)));
  endtask

  task automatic test_attribute_sweep();
    attribute_pass(8'h00);
    attribute_pass(8'hFF);
    // wrap off the last cell: blanks stay 0x0720 under any attribute
    send_word(req_word(REQ_SET_ROW, 8'h00, 8'h00, 8'(NROW - 1), 8'h00));
    send_word(req_word(REQ_SET_COL, 8'h00, 8'h00, 8'h00, 8'(NCOL - 1)));
    send_word(req_word(REQ_PUT_CURSOR, "Z", 8'h00, 8'h00, 8'h00));
    send_word(req_word(REQ_READ, 8'h00, 8'h00, 8'(NROW - 1), 8'(NCOL - 1)));
  endtask

  task automatic test_random_traffic(input int pct, input int count, input logic [7:0] attr);
    drain_results();
    set_text_attribute(attr);
    idle_pct = pct;
    repeat (count) begin
      pace();
      send_word(random_word());
    end
  endtask

  initial begin
    rst       <= 1'b1;
    start     <= 1'b0;
    req       <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    idle_pct        = 0;
    words_sent      = 0;
    results_checked = 0;
    clears_seen     = 0;
    mismatch_count  = 0;
    blank_screen();
    shadow_attr = ATTR_RESET;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_attribute_sweep();
    test_random_traffic(8, 410, 8'($urandom_range(255)));
    test_random_traffic(86, 410, 8'hA5);
    test_random_traffic(0, 410, ATTR_RESET);
    drain_results();

    $display("Summary: %0d request words sent, %0d result words checked, %0d screen clears",
             words_sent, results_checked, clears_seen);
    $display("Summary: streamed, positioned, cursor and read requests under idle mixes");
    if (mismatch_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
